[rtl/bde_pkg.sv]
// ----------------------------------------------------------------------------
// bde_pkg
// Shared constants and controller-to-datapath types for the Bezier degree
// elevation unit.
// ----------------------------------------------------------------------------
package bde_pkg;

	localparam int MAX_DEGREE  = 15;
	localparam int COEFF_WIDTH = 24;
	localparam int TARGET_W    = 4;
	localparam int INDEX_W     = 4;

	// write data source for the coefficient store
	localparam logic [1:0] WSRC_IN  = 2'd0;
	localparam logic [1:0] WSRC_RD  = 2'd1;
	localparam logic [1:0] WSRC_DIV = 2'd2;

	typedef struct packed {
		logic       we;
		logic [1:0] wsrc;
		logic       re;
		logic       hi_ld_rd;
		logic       hi_ld_lo;
		logic       mul_en;
		logic       add_en;
		logic       div_start;
		logic       out_ld;
		logic       out_last;
		logic       out_ovf;
	} bde_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} bde_stat_t;

endpackage

[rtl/bde_ifs.sv]
// ----------------------------------------------------------------------------
// bde channel interfaces
// Valid/ready channels for coefficient input, result output and configuration.
// ----------------------------------------------------------------------------
interface bde_in_if #(
	parameter int COEFF_WIDTH = bde_pkg::COEFF_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COEFF_WIDTH-1:0] coeff_in;
	logic                          last_coeff;

	modport source (output valid, coeff_in, last_coeff, input ready);
	modport sink (input valid, coeff_in, last_coeff, output ready);
endinterface

interface bde_out_if #(
	parameter int COEFF_WIDTH = bde_pkg::COEFF_WIDTH
);
	logic                              valid;
	logic                              ready;
	logic signed [COEFF_WIDTH-1:0]     coeff_out;
	logic [bde_pkg::INDEX_W-1:0]       coeff_index;
	logic                              last_out;
	logic                              overflow;

	modport source (output valid, coeff_out, coeff_index, last_out, overflow, input ready);
	modport sink (input valid, coeff_out, coeff_index, last_out, overflow, output ready);
endinterface

interface bde_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bde_pkg::TARGET_W-1:0] target_degree;

	modport source (output valid, target_degree, input ready);
	modport sink (input valid, target_degree, output ready);
endinterface

[rtl/bde_ram.sv]
// ----------------------------------------------------------------------------
// bde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bde_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/bde_div.sv]
// ----------------------------------------------------------------------------
// bde_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bde_div #(
	parameter int NW = 32,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW:0]      rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    dvs_q;
	logic [DW:0]      rem_sh;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

[rtl/bde_dp.sv]
// ----------------------------------------------------------------------------
// bde_dp
// Datapath: coefficient store, weighted sum, rounding divide, output register.
// ----------------------------------------------------------------------------
module bde_dp #(
	parameter int MAX_DEGREE  = bde_pkg::MAX_DEGREE,
	parameter int COEFF_WIDTH = bde_pkg::COEFF_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bde_pkg::bde_cmd_t                   cmd,
	output bde_pkg::bde_stat_t                  stat,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]     waddr,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]     raddr,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]     mul_i,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]     mul_mi,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]     divisor,
	input  logic [bde_pkg::INDEX_W-1:0]         out_idx,
	input  logic signed [COEFF_WIDTH-1:0]       coeff_in,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [COEFF_WIDTH-1:0]       coeff_out,
	output logic [bde_pkg::INDEX_W-1:0]         coeff_index,
	output logic                                last_out,
	output logic                                overflow
);
	import bde_pkg::*;

	localparam int SLOTS = MAX_DEGREE + 1;
	localparam int AW    = $clog2(SLOTS);
	localparam int PW    = COEFF_WIDTH + AW + 1;
	localparam int NW    = PW + 1;

	logic [COEFF_WIDTH-1:0]        wdata;
	logic [COEFF_WIDTH-1:0]        rdata;
	logic signed [COEFF_WIDTH-1:0] hi_q;
	logic signed [COEFF_WIDTH-1:0] lo_q;
	logic signed [PW-1:0]          p1_q;
	logic signed [PW-1:0]          p2_q;
	logic signed [NW-1:0]          num_q;
	logic                          neg_q;
	logic [NW-1:0]                 mag;
	logic [NW-1:0]                 dvd;
	logic                          div_done;
	logic [NW-1:0]                 quo;
	logic signed [COEFF_WIDTH-1:0] res;
	logic                          out_valid_q;

	always_comb begin
		mag = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
		dvd = mag + NW'(divisor >> 1);
		res = neg_q ? -$signed(quo[COEFF_WIDTH-1:0]) : $signed(quo[COEFF_WIDTH-1:0]);
		case (cmd.wsrc)
			WSRC_IN:  wdata = coeff_in;
			WSRC_RD:  wdata = rdata;
			WSRC_DIV: wdata = res;
			default:  wdata = rdata;
		endcase
	end

	bde_ram #(
		.WIDTH (COEFF_WIDTH),
		.DEPTH (SLOTS)
	) u_store (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.re),
		.raddr (raddr),
		.rdata (rdata)
	);

	bde_div #(
		.NW (NW),
		.DW (AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.hi_ld_rd) begin
			hi_q <= rdata;
		end else if (cmd.hi_ld_lo) begin
			hi_q <= lo_q;
		end
		if (cmd.mul_en) begin
			lo_q <= rdata;
			p1_q <= PW'($signed(rdata) * $signed({1'b0, mul_i}));
			p2_q <= PW'(hi_q * $signed({1'b0, mul_mi}));
		end
		if (cmd.add_en) begin
			num_q <= NW'(p1_q) + NW'(p2_q);
		end
		if (cmd.div_start) begin
			neg_q <= num_q[NW-1];
		end
		if (cmd.out_ld) begin
			coeff_out   <= rdata;
			coeff_index <= out_idx;
			last_out    <= cmd.out_last;
			overflow    <= cmd.out_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;
endmodule

[rtl/bde_ctrl.sv]
// ----------------------------------------------------------------------------
// bde_ctrl
// Controller: load counting, elevation sequencing and result emission.
// ----------------------------------------------------------------------------
module bde_ctrl #(
	parameter int MAX_DEGREE = bde_pkg::MAX_DEGREE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_last,
	output logic                            in_ready,
	input  logic                            cfg_valid,
	input  logic [bde_pkg::TARGET_W-1:0]    cfg_data,
	output logic                            cfg_ready,
	output bde_pkg::bde_cmd_t               cmd,
	input  bde_pkg::bde_stat_t              stat,
	output logic [$clog2(MAX_DEGREE+1)-1:0] waddr,
	output logic [$clog2(MAX_DEGREE+1)-1:0] raddr,
	output logic [$clog2(MAX_DEGREE+1)-1:0] mul_i,
	output logic [$clog2(MAX_DEGREE+1)-1:0] mul_mi,
	output logic [$clog2(MAX_DEGREE+1)-1:0] divisor,
	output logic [bde_pkg::INDEX_W-1:0]     out_idx
);
	import bde_pkg::*;

	localparam int SLOTS = MAX_DEGREE + 1;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_CPRD = 4'd1;
	localparam logic [3:0] S_CPWR = 4'd2;
	localparam logic [3:0] S_RD   = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_ADD  = 4'd5;
	localparam logic [3:0] S_DIVS = 4'd6;
	localparam logic [3:0] S_DIVW = 4'd7;
	localparam logic [3:0] S_EMRD = 4'd8;
	localparam logic [3:0] S_EMLD = 4'd9;

	logic [3:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic                drop_q;
	logic [TARGET_W-1:0] target_q;
	logic [AW-1:0]       tgt_q;
	logic [AW-1:0]       m_q;
	logic [AW-1:0]       i_q;
	logic [AW-1:0]       k_q;
	logic [CW-1:0]       total_q;
	logic [AW-1:0]       tgt_lim;
	logic                has_room;
	logic [CW-1:0]       cnt_new;
	logic                emit_last;

	always_comb begin
		tgt_lim   = (int'(target_q) > MAX_DEGREE) ? AW'(MAX_DEGREE) : AW'(target_q);
		has_room  = cnt_q < CW'(SLOTS);
		cnt_new   = has_room ? cnt_q + 1'b1 : cnt_q;
		emit_last = (CW'(k_q) + 1'b1) == total_q;
	end

	always_comb begin
		cmd      = '0;
		cmd.wsrc = WSRC_IN;
		waddr    = cnt_q[AW-1:0];
		raddr    = k_q;
		mul_i    = i_q;
		mul_mi   = m_q - i_q;
		divisor  = m_q;
		out_idx  = INDEX_W'(k_q);
		in_ready = 1'b0;
		cmd.out_last = emit_last;
		cmd.out_ovf  = drop_q;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.we   = in_valid && has_room;
			end
			S_CPRD: begin
				cmd.re = 1'b1;
				raddr  = m_q - 1'b1;
			end
			S_CPWR: begin
				cmd.we       = 1'b1;
				cmd.wsrc     = WSRC_RD;
				waddr        = m_q;
				cmd.hi_ld_rd = 1'b1;
			end
			S_RD: begin
				cmd.re = 1'b1;
				raddr  = i_q - 1'b1;
			end
			S_MUL:  cmd.mul_en    = 1'b1;
			S_ADD:  cmd.add_en    = 1'b1;
			S_DIVS: cmd.div_start = 1'b1;
			S_DIVW: begin
				cmd.we       = stat.div_done;
				cmd.wsrc     = WSRC_DIV;
				waddr        = i_q;
				cmd.hi_ld_lo = stat.div_done;
			end
			S_EMRD: cmd.re     = stat.out_free;
			S_EMLD: cmd.out_ld = 1'b1;
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			target_q <= '0;
			tgt_q    <= '0;
			m_q      <= '0;
			i_q      <= '0;
			k_q      <= '0;
			total_q  <= '0;
		end else begin
			if (cfg_valid) begin
				target_q <= cfg_data;
			end
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						cnt_q <= cnt_new;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (in_last) begin
							tgt_q   <= tgt_lim;
							total_q <= (cnt_new > CW'(tgt_lim)) ? cnt_new : CW'(tgt_lim) + 1'b1;
							k_q     <= '0;
							// source degree is below target: start elevating at m = count
							if (cnt_new <= CW'(tgt_lim)) begin
								m_q     <= cnt_new[AW-1:0];
								state_q <= S_CPRD;
							end else begin
								state_q <= S_EMRD;
							end
						end
					end
				end
				S_CPRD: state_q <= S_CPWR;
				S_CPWR: begin
					if (m_q == AW'(1)) begin
						if (m_q == tgt_q) begin
							state_q <= S_EMRD;
						end else begin
							m_q     <= m_q + 1'b1;
							state_q <= S_CPRD;
						end
					end else begin
						i_q     <= m_q - 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD:   state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD:  state_q <= S_DIVS;
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: begin
					if (stat.div_done) begin
						if (i_q == AW'(1)) begin
							if (m_q == tgt_q) begin
								state_q <= S_EMRD;
							end else begin
								m_q     <= m_q + 1'b1;
								state_q <= S_CPRD;
							end
						end else begin
							i_q     <= i_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_EMRD: begin
					if (stat.out_free) begin
						state_q <= S_EMLD;
					end
				end
				S_EMLD: begin
					k_q <= k_q + 1'b1;
					if (emit_last) begin
						cnt_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_EMRD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

[rtl/bezier_degree_elevation_unit.sv]
// ----------------------------------------------------------------------------
// bezier_degree_elevation_unit
// Loads a set of Bezier coefficients, raises its degree to the configured target
// if below it, and streams the coefficients out in index order.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | beat
//  in_ch    | in  | coeff_in, last_coeff                         | one coefficient
//  out_ch   | out | coeff_out, coeff_index, last_out, overflow   | one coefficient
//  cfg_ch   | in  | target_degree                                | one write
//
// a load beat takes one cycle; the set is closed by last_coeff
// each elevated coefficient takes a store read, multiply, add and one divider
// pass (S_RD, S_MUL, S_ADD, S_DIVS, S_DIVW); about M*M/2 such steps per set
// emission reads each beat from the store through the single read port
// in_ch is held off from the closing beat until the last result is loaded
// reset clears control state only; the store needs no clearing
// ----------------------------------------------------------------------------
module bezier_degree_elevation_unit #(
	parameter int MAX_DEGREE  = bde_pkg::MAX_DEGREE,
	parameter int COEFF_WIDTH = bde_pkg::COEFF_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	bde_in_if.sink    in_ch,
	bde_out_if.source out_ch,
	bde_cfg_if.sink   cfg_ch
);
	import bde_pkg::*;

	localparam int AW = $clog2(MAX_DEGREE + 1);

	bde_cmd_t         cmd;
	bde_stat_t        stat;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    mul_i;
	logic [AW-1:0]    mul_mi;
	logic [AW-1:0]    divisor;
	logic [INDEX_W-1:0] out_idx;

	bde_ctrl #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_coeff),
		.in_ready  (in_ch.ready),
		.cfg_valid (cfg_ch.valid),
		.cfg_data  (cfg_ch.target_degree),
		.cfg_ready (cfg_ch.ready),
		.cmd       (cmd),
		.stat      (stat),
		.waddr     (waddr),
		.raddr     (raddr),
		.mul_i     (mul_i),
		.mul_mi    (mul_mi),
		.divisor   (divisor),
		.out_idx   (out_idx)
	);

	bde_dp #(
		.MAX_DEGREE  (MAX_DEGREE),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.waddr       (waddr),
		.raddr       (raddr),
		.mul_i       (mul_i),
		.mul_mi      (mul_mi),
		.divisor     (divisor),
		.out_idx     (out_idx),
		.coeff_in    (in_ch.coeff_in),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.coeff_out   (out_ch.coeff_out),
		.coeff_index (out_ch.coeff_index),
		.last_out    (out_ch.last_out),
		.overflow    (out_ch.overflow)
	);
endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Bezier degree elevation unit: random and
// directed coefficient sets at several target degrees, with a scoreboard that
// elevates each set itself and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb_top;
	import bde_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [COEFF_WIDTH-1:0] coeff_t;

	typedef struct packed {
		logic signed [COEFF_WIDTH-1:0] coeff;
		logic [INDEX_W-1:0]            index;
		logic                          last;
		logic                          ovf;
	} elev_beat_t;

	class elevation_board;
		longint     store[MAX_DEGREE+1];
		int         count;
		bit         dropped;
		int         target;
		elev_beat_t pending[$];
		int         errors;

		function void clear();
			count = 0;
			dropped = 0;
			target = 0;
			errors = 0;
			pending.delete();
		endfunction

		function longint div_round(longint num, longint den);
			if (num >= 0) begin
				return (num + den / 2) / den;
			end else begin
				return -((-num + den / 2) / den);
			end
		endfunction

		function void note_coeff(coeff_t c, logic last);
			int         n;
			int         tgt;
			int         total;
			longint     num;
			elev_beat_t b;
			if (count < MAX_DEGREE + 1) begin
				store[count] = c;
				count++;
			end else begin
				dropped = 1;
			end
			if (!last) return;
			n = count - 1;
			tgt = (target > MAX_DEGREE) ? MAX_DEGREE : target;
			for (int m = n + 1; m <= tgt; m++) begin
				store[m] = store[m-1];
				for (int i = m - 1; i >= 1; i--) begin
					num = longint'(i) * store[i-1] + longint'(m - i) * store[i];
					store[i] = div_round(num, m);
				end
			end
			total = ((tgt > n) ? tgt : n) + 1;
			for (int k = 0; k < total; k++) begin
				b.coeff = coeff_t'(store[k]);
				b.index = k[INDEX_W-1:0];
				b.last  = (k + 1 == total);
				b.ovf   = dropped;
				pending.push_back(b);
			end
			count = 0;
			dropped = 0;
		endfunction

		function void check_beat(elev_beat_t got);
			elev_beat_t exp_b;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
				return;
			end
			exp_b = pending.pop_front();
			if (got.coeff !== exp_b.coeff || got.index !== exp_b.index ||
			    got.last !== exp_b.last || got.ovf !== exp_b.ovf) begin
				$display("%0t: mismatch expected c=%0d i=%0d l=%0b o=%0b actual c=%0d i=%0d l=%0b o=%0b",
					$time, exp_b.coeff, exp_b.index, exp_b.last, exp_b.ovf,
					got.coeff, got.index, got.last, got.ovf);
				errors++;
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	bde_in_if  in_ch();
	bde_out_if out_ch();
	bde_cfg_if cfg_ch();

	elevation_board board = new();
	int  idle_cycles = 0;
	bit  hold_off = 0;

	always #4 clk = ~clk;

	bezier_degree_elevation_unit uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	initial begin
		in_ch.valid = 0;
		in_ch.coeff_in = '0;
		in_ch.last_coeff = 0;
		out_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.target_degree = '0;
		board.clear();
	end

	// receiver stall pattern, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_off) begin
			out_ch.ready <= 0;
		end else begin
			case ($urandom_range(0, 3))
				0: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= 1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			board.check_beat({out_ch.coeff_out, out_ch.coeff_index, out_ch.last_out,
				out_ch.overflow});
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_coeff(coeff_t c, logic last);
		int gap;
		in_ch.valid <= 1;
		in_ch.coeff_in <= c;
		in_ch.last_coeff <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_coeff(c, last);
		// bursts: mostly back to back, sometimes a gap
		if ($urandom_range(0, 4) == 0) begin
			in_ch.valid <= 0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		in_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_target(int tgt);
		cfg_ch.valid <= 1;
		cfg_ch.target_degree <= tgt[TARGET_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 0;
		board.target = tgt;
		@(posedge clk);
	endtask

	function automatic coeff_t rand_coeff();
		case ($urandom_range(0, 5))
			0: return coeff_t'(-(1 << (COEFF_WIDTH - 1)));
			1: return coeff_t'((1 << (COEFF_WIDTH - 1)) - 1);
			default: return coeff_t'($urandom);
		endcase
	endfunction

	task automatic send_set(int len);
		for (int k = 0; k < len; k++) send_coeff(rand_coeff(), k == len - 1);
		end_burst();
	endtask

	initial begin
		int sent;
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset target: sets come back unchanged
		send_coeff(coeff_t'(-(1 << (COEFF_WIDTH - 1))), 1);
		send_coeff(coeff_t'((1 << (COEFF_WIDTH - 1)) - 1), 0);
		send_coeff(coeff_t'(0), 1);
		end_burst();
		drain();

		// elevate to the top degree, single and extreme pair
		write_target(15);
		send_coeff(coeff_t'(-1), 1);
		send_coeff(coeff_t'(-(1 << (COEFF_WIDTH - 1))), 0);
		send_coeff(coeff_t'((1 << (COEFF_WIDTH - 1)) - 1), 1);
		// rounding ties on both signs
		send_coeff(coeff_t'(-3), 0);
		send_coeff(coeff_t'(3), 1);
		end_burst();
		drain();

		// overflow of storage, target below source
		write_target(3);
		send_set(18);
		drain();

		// long hold-off on the receiver while the sender keeps offering
		write_target(12);
		hold_off = 1;
		fork
			begin
				send_set(3);
				send_set(2);
			end
			begin
				// outlasts the first elevation so results back up
				repeat (4000) @(posedge clk);
				hold_off = 0;
			end
		join
		hold_off = 0;
		drain();

		sent = 0;
		while (sent < 100) begin
			if ($urandom_range(0, 3) == 0) begin
				drain();
				write_target($urandom_range(0, 15));
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
			send_set(len);
			sent += len;
		end
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
